// ----- hdl/sidmf_pkg.sv -----
package sidmf_pkg;

  localparam int unsigned CAPACITY_DEF = 64;

  typedef enum logic [2:0] {
    FN_CHECK  = 3'd0,
    FN_ADD    = 3'd1,
    FN_REMOVE = 3'd2,
    FN_NONE   = 3'd3,
    FN_ALL    = 3'd4,
    FN_LIST   = 3'd5,
    FN_QUERY  = 3'd6,
    FN_SPARE  = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_ALL  = 2'd1,
    MODE_LIST = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOSUP = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] uid;
  } cmd_t;

  typedef struct packed {
    logic       passed;
    logic       was_member;
    logic [1:0] status;
    logic [1:0] prior_mode;
    logic [6:0] id_count;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SREAD,
    S_SCMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_t;

endpackage

// ----- hdl/sorted_id_membership_filter.sv -----
// Result strobe: mode commands, query and any word that needs no search go
//   straight from idle to the strobe state; a list search alternates a read
//   and a compare state per probe, and an add or remove that changes the
//   table then moves entries through shift read and write states first.
// Throughput: one word at a time; busy stays high through the strobe cycle.
//   Search and shift share the table's one read port and one write port.
// Reset: synchronous; mode goes to pass none and the count to zero. The
//   table is not cleared. The receiver cannot stall the result strobe.
module sorted_id_membership_filter #(
  parameter int unsigned CAPACITY = sidmf_pkg::CAPACITY_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  sidmf_pkg::cmd_t  cmd,
  output logic             busy,
  output logic             done,
  output sidmf_pkg::rsp_t  rsp
);
  import sidmf_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // table memory
  logic [31:0] mem [CAPACITY];
  logic [31:0] rd_data;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [31:0] wr_data;
  logic rd_en, wr_en;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // control registers
  state_t state, state_next;
  mode_t mode, mode_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] lo, lo_next, hi, hi_next, idx, idx_next;
  func_t fn, fn_next;
  logic [31:0] uid, uid_next;
  logic [31:0] hold, hold_next;
  logic found, found_next;
  mode_t prior, prior_next;
  rsp_t res, res_next;

  // midpoint with one spare bit for the sum
  logic [CW:0] mid_sum;
  logic [CW-1:0] mid;
  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid = mid_sum[CW:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode  <= MODE_NONE;
      count <= '0;
    end else begin
      state <= state_next;
      mode  <= mode_next;
      count <= count_next;
    end
    lo <= lo_next; hi <= hi_next; idx <= idx_next;
    fn <= fn_next; uid <= uid_next; hold <= hold_next;
    found <= found_next; prior <= prior_next; res <= res_next;
  end

  // wrap-up of a finished search
  rsp_t fin;
  logic [CW-1:0] fin_count;
  logic fin_shift;
  logic [CW-1:0] fin_idx;

  always_comb begin
    fin = '0;
    fin.prior_mode = prior;
    fin_count = count;
    fin_shift = 1'b0;
    fin_idx = count;
    case (fn)
      FN_CHECK: fin.passed = found;
      FN_ADD: begin
        fin.was_member = found;
        if (!found) begin
          if (count >= CW'(CAPACITY)) fin.status = ST_FULL;
          else begin
            fin_shift = 1'b1;
            fin_idx = count;
          end
        end
      end
      FN_REMOVE: begin
        fin.was_member = found;
        if (found) begin
          fin_shift = 1'b1;
          fin_idx = lo;
        end
      end
      default: ;
    endcase
    fin.id_count = 7'(fin_count);
  end

  always_comb begin
    state_next = state;
    mode_next = mode; count_next = count;
    lo_next = lo; hi_next = hi; idx_next = idx;
    fn_next = fn; uid_next = uid; hold_next = hold;
    found_next = found; prior_next = prior; res_next = res;
    rd_en = 1'b0; rd_addr = mid[AW-1:0];
    wr_en = 1'b0; wr_addr = idx[AW-1:0]; wr_data = hold;
    busy = (state != S_IDLE);
    done = (state == S_DONE);
    rsp = res;
    case (state)
      S_IDLE: begin
        if (start) begin
          fn_next = func_t'(cmd.func);
          uid_next = cmd.uid;
          prior_next = mode;
          lo_next = '0;
          hi_next = count;
          found_next = 1'b0;
          res_next = '0;
          res_next.prior_mode = mode;
          state_next = S_DONE;
          case (func_t'(cmd.func))
            FN_CHECK, FN_ADD, FN_REMOVE: begin
              if (mode == MODE_ALL) begin
                found_next = 1'b1;
                res_next.passed = (cmd.func == FN_CHECK);
                res_next.was_member = (cmd.func != FN_CHECK);
                res_next.status = (cmd.func == FN_REMOVE) ? ST_NOSUP : ST_OK;
                res_next.id_count = 7'(count);
              end else if (mode == MODE_NONE) begin
                if (cmd.func == FN_ADD) begin
                  // first id: becomes a one-entry list
                  wr_en = 1'b1; wr_addr = '0; wr_data = cmd.uid;
                  mode_next = MODE_LIST; count_next = CW'(1);
                  res_next.id_count = 7'd1;
                end else res_next.id_count = 7'(count);
              end else state_next = S_SREAD;
            end
            FN_NONE: begin mode_next = MODE_NONE; count_next = '0; end
            FN_ALL:  begin mode_next = MODE_ALL;  count_next = '0; end
            FN_LIST: begin mode_next = MODE_LIST; count_next = '0; end
            default: res_next.id_count = 7'(count);
          endcase
        end
      end
      // binary search: read mid, then compare
      S_SREAD: begin
        if (hi > lo) begin
          rd_en = 1'b1;
          state_next = S_SCMP;
        end else begin
          res_next = fin;
          if (fin_shift) begin
            idx_next = fin_idx;
            state_next = (fn == FN_ADD && fin_idx == lo) ? S_SHIFT_WR : S_SHIFT_RD;
            hold_next = uid;
          end else state_next = S_DONE;
        end
      end
      S_SCMP: begin
        if (uid > rd_data) begin
          lo_next = mid + CW'(1);
          state_next = S_SREAD;
        end else if (uid < rd_data) begin
          hi_next = mid;
          state_next = S_SREAD;
        end else begin
          lo_next = mid; hi_next = mid;
          found_next = 1'b1;
          state_next = S_SREAD;
        end
      end
      // add walks down from count, remove walks up from the hit
      S_SHIFT_RD: begin
        rd_en = 1'b1;
        rd_addr = (fn == FN_ADD) ? AW'(idx - CW'(1)) : AW'(idx + CW'(1));
        if (fn == FN_REMOVE && idx + CW'(1) >= count) begin
          rd_en = 1'b0;
          count_next = count - CW'(1);
          if (count == CW'(1)) mode_next = MODE_NONE;
          res_next.id_count = 7'(count - CW'(1));
          state_next = S_DONE;
        end else state_next = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        wr_en = 1'b1;
        if (fn == FN_ADD && idx == lo) begin
          wr_data = uid;
          count_next = count + CW'(1);
          mode_next = MODE_LIST;
          res_next.id_count = 7'(count + CW'(1));
          state_next = S_DONE;
        end else begin
          wr_data = rd_data;
          idx_next = (fn == FN_ADD) ? idx - CW'(1) : idx + CW'(1);
          state_next = S_SHIFT_RD;
          if (fn == FN_ADD && idx - CW'(1) == lo) state_next = S_SHIFT_WR;
        end
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- hdl/sidmf_checker.sv -----
module sidmf_checker (
  input logic            clk,
  input logic            rst,
  input logic            start,
  input logic            busy,
  input logic            done,
  input sidmf_pkg::rsp_t rsp
);
  import sidmf_pkg::*;

  // accepted word makes the block busy
  a_take: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("no busy after accept");

  // strobe only while busy, then drop
  a_done: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("strobe while idle");
  a_once: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("double strobe");

  // results are consistent
  a_pass: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.passed) |-> (rsp.prior_mode != MODE_NONE))
    else $error("pass in pass-none mode");
  a_stat: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == ST_NOSUP) |-> (rsp.prior_mode == MODE_ALL))
    else $error("refusal outside pass-all");
endmodule

bind sorted_id_membership_filter sidmf_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .rsp(rsp)
);
